>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/mtxfw_pkg.sv
`default_nettype none
package mtxfw_pkg;

    localparam int DEF_NUM_MUTEX = 32;
    localparam int DEF_NUM_TASKS = 64;

    localparam int CMDW  = 2;
    localparam int IDXW  = 6;
    localparam int TASKW = 6;
    localparam int PRIOW = 6;
    localparam int STW   = 3;
    localparam int CRW   = 5;
    localparam int HOLDW = 6;

    localparam logic [HOLDW-1:0] HOLD_MAX = 6'd63;

    localparam logic [CMDW-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMDW-1:0] CMD_LOCK   = 2'd1;
    localparam logic [CMDW-1:0] CMD_UNLOCK = 2'd2;
    localparam logic [CMDW-1:0] CMD_BAD    = 2'd3;

    localparam logic [STW-1:0] ST_OK       = 3'd0;
    localparam logic [STW-1:0] ST_NOMEM    = 3'd1;
    localparam logic [STW-1:0] ST_INVAL    = 3'd2;
    localparam logic [STW-1:0] ST_DEADLOCK = 3'd3;
    localparam logic [STW-1:0] ST_PERM     = 3'd4;

    typedef struct packed {
        logic [STW-1:0]   status;
        logic [CRW-1:0]   created;
        logic             blocked;
        logic             wvalid;
        logic [TASKW-1:0] wtask;
        logic             pchg;
        logic [PRIOW-1:0] pnew;
    } t_result;

    function automatic logic [HOLDW-1:0] hold_inc(input logic [HOLDW-1:0] h);
        return (h == HOLD_MAX) ? h : h + 1'b1;
    endfunction

    function automatic logic [HOLDW-1:0] hold_dec(input logic [HOLDW-1:0] h);
        return (h == '0) ? h : h - 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mutex_table_with_fifo_waiters_unit.sv
// Mutex lock manager with per-mutex FIFO wait queues.
// Input channel: i_valid / o_ready, one request per transfer (create, lock
// or unlock, mutex index, caller task, caller native priority).
// Output channel: o_valid / i_ready, one result per request, carrying the
// status, the created index, blocked / woken flags and the caller's new
// priority.
// The result is loaded in S_EXEC, from the registered request and table
// reads; an unlock that hands the mutex to a waiter loads it in S_WAKE,
// since the head waiter's link and hold count need a second read of the
// task tables. Mutex entries and task entries live in memories with a
// registered read, so each request does one read pass (two on a hand-off)
// and then writes back; o_ready returns the cycle after the load.
// A new request is taken while the previous result still waits in the
// output register. If the receiver stalls, the block finishes its next
// request up to the write-back and holds there until the output register
// frees; only a hand-off has already stored the caller's lowered hold count.
// Reset clears the allocated, locked, waiter, link-valid and hold-valid
// flags at once, so hold counts read as zero; no clearing pass is needed and
// the block is ready the cycle after reset is released.
`default_nettype none
module mutex_table_with_fifo_waiters_unit
    import mtxfw_pkg::*;
#(
    parameter int NUM_MUTEX = DEF_NUM_MUTEX,
    parameter int NUM_TASKS = DEF_NUM_TASKS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [CMDW-1:0]  i_command,
    input  wire logic [IDXW-1:0]  i_mutex_index,
    input  wire logic [TASKW-1:0] i_caller_task,
    input  wire logic [PRIOW-1:0] i_native_priority,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [STW-1:0]        o_status,
    output logic [CRW-1:0]        o_created_index,
    output logic                  o_caller_blocked,
    output logic                  o_woken_valid,
    output logic [TASKW-1:0]      o_woken_task,
    output logic                  o_priority_change,
    output logic [PRIOW-1:0]      o_caller_new_priority
);

    localparam int MW = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAKE} t_state;

    typedef struct packed {
        logic [TW-1:0] owner;
        logic [TW-1:0] head;
        logic [TW-1:0] tail;
    } t_mtx_ent;

    t_mtx_ent         mem_mtx  [NUM_MUTEX];
    logic [HOLDW-1:0] mem_hold [NUM_TASKS];
    logic [TW-1:0]    mem_next [NUM_TASKS];

    t_state           r_state, n_state;
    logic [CMDW-1:0]  r_cmd;
    logic [IDXW-1:0]  r_m;
    logic [TASKW-1:0] r_t;
    logic [PRIOW-1:0] r_nat;
    t_mtx_ent         r_mq;
    logic [HOLDW-1:0] r_hold_rd;
    logic [TW-1:0]    r_next_rd;
    logic [HOLDW-1:0] r_hold_dn, n_hold_dn;

    logic [NUM_MUTEX-1:0] r_alloc, r_locked, r_wp;
    logic [NUM_TASKS-1:0] r_nvalid, r_hvalid, n_nvalid;
    logic [IDXW-1:0]      r_free_idx, n_free_idx;
    logic                 r_free_any, n_free_any;

    logic    r_o_valid;
    t_result r_res, n_res;

    logic in_acc, go, res_load;
    logic m_ok, t_ok;
    logic [MW-1:0] m_i;
    logic [TW-1:0] t_i, h_i;
    logic alloc_m, locked_m, wp_m, owner_eq;
    logic [HOLDW-1:0] hold_t, hold_h, hold_h_up;

    logic             mtx_we;
    t_mtx_ent         mtx_wd;
    logic             hold_we, hold_re;
    logic [TW-1:0]    hold_wa, hold_ra;
    logic [HOLDW-1:0] hold_wd;
    logic             next_we, next_re;
    logic             alloc_set, lock_set, lock_clr, wp_set, wp_clr;
    logic             nv_clr, nv_set;
    logic [TW-1:0]    nv_clr_idx;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign go      = !r_o_valid || i_ready;

    assign m_ok = ({1'b0, r_m} < 7'(NUM_MUTEX));
    assign t_ok = ({1'b0, r_t} < 7'(NUM_TASKS));
    assign m_i  = r_m[MW-1:0];
    assign t_i  = r_t[TW-1:0];
    assign h_i  = r_mq.head;

    assign alloc_m  = m_ok && r_alloc[m_i];
    assign locked_m = r_locked[m_i];
    assign wp_m     = r_wp[m_i];
    assign owner_eq = (r_mq.owner == t_i);
    assign hold_t   = r_hvalid[t_i] ? r_hold_rd : '0;
    // head waiter may be the releasing task itself
    assign hold_h    = (h_i == t_i) ? r_hold_dn : (r_hvalid[h_i] ? r_hold_rd : '0);
    assign hold_h_up = hold_inc(hold_h);

    always_comb begin
        n_free_idx = '0;
        n_free_any = 1'b0;
        for (int i = NUM_MUTEX - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                n_free_idx = IDXW'(i);
                n_free_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = '0;
        n_hold_dn  = r_hold_dn;
        res_load   = 1'b0;
        mtx_we     = 1'b0;
        mtx_wd     = r_mq;
        hold_we    = 1'b0;
        hold_wa    = t_i;
        hold_wd    = '0;
        hold_re    = in_acc;
        hold_ra    = i_caller_task[TW-1:0];
        next_we    = 1'b0;
        next_re    = 1'b0;
        alloc_set  = 1'b0;
        lock_set   = 1'b0;
        lock_clr   = 1'b0;
        wp_set     = 1'b0;
        wp_clr     = 1'b0;
        nv_clr     = 1'b0;
        nv_set     = 1'b0;
        nv_clr_idx = t_i;
        n_res.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_CREATE) begin
                    if (r_free_any) begin
                        alloc_set     = go;
                        n_res.created = r_free_idx[CRW-1:0];
                    end else begin
                        n_res.status = ST_NOMEM;
                    end
                    res_load = go;
                end else if (r_cmd == CMD_BAD || !m_ok || !t_ok || !alloc_m) begin
                    n_res.status = ST_INVAL;
                    res_load     = go;
                end else if (r_cmd == CMD_LOCK) begin
                    res_load = go;
                    if (locked_m && owner_eq) begin
                        n_res.status = ST_DEADLOCK;
                    end else if (!locked_m) begin
                        lock_set     = go;
                        mtx_we       = go;
                        mtx_wd.owner = t_i;
                        hold_we      = go;
                        hold_wd      = hold_inc(hold_t);
                        n_res.pchg   = 1'b1;
                    end else begin
                        nv_clr        = go;
                        mtx_we        = go;
                        mtx_wd.tail   = t_i;
                        n_res.blocked = 1'b1;
                        if (!wp_m) begin
                            mtx_wd.head = t_i;
                            wp_set      = go;
                        end else begin
                            next_we = go;
                            nv_set  = go;
                        end
                    end
                end else begin
                    if (!locked_m || !owner_eq) begin
                        n_res.status = ST_PERM;
                        res_load     = go;
                    end else if (wp_m) begin
                        n_hold_dn = hold_dec(hold_t);
                        hold_we   = 1'b1;
                        hold_wd   = hold_dec(hold_t);
                        hold_re   = 1'b1;
                        hold_ra   = h_i;
                        next_re   = 1'b1;
                        n_state   = S_WAKE;
                    end else begin
                        hold_we   = go;
                        hold_wd   = hold_dec(hold_t);
                        lock_clr  = go;
                        res_load  = go;
                        if (hold_dec(hold_t) == '0) begin
                            n_res.pchg = 1'b1;
                            n_res.pnew = r_nat;
                        end
                    end
                end
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            S_WAKE: begin
                hold_wa      = h_i;
                hold_wd      = hold_h_up;
                mtx_wd.owner = h_i;
                nv_clr_idx   = h_i;
                if (r_nvalid[h_i]) begin
                    mtx_wd.head = r_next_rd;
                end
                n_res.wvalid = 1'b1;
                n_res.wtask  = TASKW'(h_i);
                if (((h_i == t_i) ? hold_h_up : r_hold_dn) == '0) begin
                    n_res.pchg = 1'b1;
                    n_res.pnew = r_nat;
                end
                if (go) begin
                    hold_we  = 1'b1;
                    mtx_we   = 1'b1;
                    nv_clr   = r_nvalid[h_i];
                    wp_clr   = !r_nvalid[h_i];
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_nvalid = r_nvalid;
        // clear before set: a task re-queued behind itself links to itself
        if (nv_clr) begin
            n_nvalid[nv_clr_idx] = 1'b0;
        end
        if (nv_set) begin
            n_nvalid[r_mq.tail] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mq <= mem_mtx[i_mutex_index[MW-1:0]];
        end
        if (mtx_we) begin
            mem_mtx[m_i] <= mtx_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_re) begin
            r_hold_rd <= mem_hold[hold_ra];
        end
        if (hold_we) begin
            mem_hold[hold_wa] <= hold_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_re) begin
            r_next_rd <= mem_next[h_i];
        end
        if (next_we) begin
            mem_next[r_mq.tail] <= t_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_alloc    <= '0;
            r_locked   <= '0;
            r_wp       <= '0;
            r_nvalid   <= '0;
            r_hvalid   <= '0;
            r_free_idx <= '0;
            r_free_any <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_idx <= n_free_idx;
            r_free_any <= n_free_any;
            r_hold_dn  <= n_hold_dn;
            r_nvalid   <= n_nvalid;
            if (in_acc) begin
                r_cmd <= i_command;
                r_m   <= i_mutex_index;
                r_t   <= i_caller_task;
                r_nat <= i_native_priority;
            end
            if (res_load) begin
                r_o_valid <= 1'b1;
                r_res     <= n_res;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (alloc_set) begin
                r_alloc[r_free_idx[MW-1:0]] <= 1'b1;
            end
            if (lock_set) begin
                r_locked[m_i] <= 1'b1;
            end
            if (lock_clr) begin
                r_locked[m_i] <= 1'b0;
            end
            if (wp_set) begin
                r_wp[m_i] <= 1'b1;
            end
            if (wp_clr) begin
                r_wp[m_i] <= 1'b0;
            end
            if (hold_we) begin
                r_hvalid[hold_wa] <= 1'b1;
            end
        end
    end

    assign o_valid               = r_o_valid;
    assign o_status              = r_res.status;
    assign o_created_index       = r_res.created;
    assign o_caller_blocked      = r_res.blocked;
    assign o_woken_valid         = r_res.wvalid;
    assign o_woken_task          = r_res.wtask;
    assign o_priority_change     = r_res.pchg;
    assign o_caller_new_priority = r_res.pnew;

endmodule
`default_nettype wire

>>> rtl/core/mtxfw_chk.sv
`default_nettype none
`include "assert_macros.svh"
module mtxfw_chk
    import mtxfw_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [STW-1:0]   o_status,
    input wire logic [CRW-1:0]   o_created_index,
    input wire logic             o_caller_blocked,
    input wire logic             o_woken_valid,
    input wire logic [TASKW-1:0] o_woken_task,
    input wire logic             o_priority_change,
    input wire logic [PRIOW-1:0] o_caller_new_priority
);

    logic                           stalled, err_side, blk_side, idle_nz;
    logic [STW+CRW+TASKW+PRIOW+2:0] res;

    assign stalled  = o_valid && !i_ready;
    assign res      = {o_status, o_created_index, o_caller_blocked, o_woken_valid,
                       o_woken_task, o_priority_change, o_caller_new_priority};
    assign err_side = (o_status != ST_OK) && ((o_created_index != '0) || o_caller_blocked
                      || o_woken_valid || o_priority_change);
    assign blk_side = o_caller_blocked && (o_woken_valid || o_priority_change);
    assign idle_nz  = (!o_woken_valid && (o_woken_task != '0))
                      || (!o_priority_change && (o_caller_new_priority != '0));

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, stalled |=> o_valid && $stable(res), "result moved")
    `ASSERT_NEVER(a_err_clean, i_clk, i_rst_n, o_valid && err_side, "error with side flags")
    `ASSERT_NEVER(a_blk_excl, i_clk, i_rst_n, o_valid && blk_side, "blocked and woken")
    `ASSERT_NEVER(a_zero_fill, i_clk, i_rst_n, o_valid && idle_nz, "unused field not zero")

endmodule

bind mutex_table_with_fifo_waiters_unit mtxfw_chk u_mtxfw_chk (.*);
`default_nettype wire
